[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mdec checker: property failed");

// checked in every cycle, reset included
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("mdec checker: property failed");

`endif

[rtl/core/mdec_pkg.sv]
// Package for the meter reply frame decoder: frame constants, CRC table
// function and the control struct passed between frame and CRC logic.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mdec_pkg;

  localparam int FRAME_BYTES = 25;

  typedef logic [4:0]  pos_t;
  typedef logic [15:0] crc_t;

  localparam pos_t MEAS_LEN = 5'd25;
  localparam pos_t ADDR_LEN = 5'd7;
  localparam pos_t POS_MAX  = 5'd31;

  localparam crc_t CRC_INIT = 16'hFFFF;
  localparam crc_t CRC_POLY = 16'hA001;

  typedef struct packed {
    logic restart;
    logic take;
  } crc_ctrl_t;

  // one entry of the reflected CRC-16 table
  function automatic crc_t crc_entry(input logic [7:0] idx);
    crc_t c;
    c = {8'h00, idx};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/meter_reply_frame_decoder.sv]
// Meter reply frame decoder, top level.
// Depends on mdec_pkg, mdec_frame and mdec_crc.
//
// Usage:
//   Input channel in_valid/in_ready carries one reply byte per item (rx_byte)
//   with frame_start set on byte 0 of a reply. Output channel
//   out_valid/out_ready carries one result item per completed frame: the
//   held meter values, the device address and crc_good.
//   Config channel cfg_valid/cfg_ready writes reply_kind (0 = 25-byte
//   measurement reply, 1 = 7-byte address reply); cfg_ready is always high.
//   Write it only while no item is in flight.
// Timing:
//   One item per cycle sustained while results are taken. An accepted byte
//   waits in the input register until one pass updates position, CRC and
//   byte store; that pass loads a last byte's result into the held values.
// Reset (rst, synchronous): position 0, CRC 0xFFFF, held values 0,
//   reply_kind 0, both channels empty.
// Stall: while a result waits on out_ready, the held values double as the
//   output register; one more byte is taken into the input register and
//   in_ready then drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module meter_reply_frame_decoder
  import mdec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        reply_kind,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      voltage_raw,
  output logic [31:0]      current_raw,
  output logic [31:0]      power_raw,
  output logic [31:0]      energy_raw,
  output logic [15:0]      frequency_raw,
  output logic [15:0]      power_factor_raw,
  output logic [15:0]      alarm_word,
  output logic [7:0]       device_address,
  output logic             crc_good
);

  logic       kind;
  logic       in_full;
  logic [7:0] rx_byte_q;
  logic       frame_start_q;
  logic       step;
  logic       result;
  crc_ctrl_t  crc_ctrl;
  crc_t       crc_value;

  assign cfg_ready = 1'b1;
  assign step      = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= 1'b0;
    end else if (cfg_valid) begin
      kind <= reply_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rx_byte_q     <= rx_byte;
      frame_start_q <= frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  mdec_frame u_frame (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .kind             (kind),
    .rx_byte          (rx_byte_q),
    .frame_start      (frame_start_q),
    .crc_value        (crc_value),
    .crc_ctrl         (crc_ctrl),
    .result           (result),
    .voltage_raw      (voltage_raw),
    .current_raw      (current_raw),
    .power_raw        (power_raw),
    .energy_raw       (energy_raw),
    .frequency_raw    (frequency_raw),
    .power_factor_raw (power_factor_raw),
    .alarm_word       (alarm_word),
    .device_address   (device_address),
    .crc_good         (crc_good)
  );

  mdec_crc u_crc (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (crc_ctrl),
    .rx_byte   (rx_byte_q),
    .crc_value (crc_value)
  );

endmodule

`default_nettype wire

[rtl/core/mdec_crc.sv]
// CRC-16 accumulator, one byte per step, table form.
// Depends on mdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mdec_crc
  import mdec_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire crc_ctrl_t ctrl,
  input  wire logic [7:0] rx_byte,
  output crc_t           crc_value
);

  crc_t crc;
  crc_t crc_cur;
  crc_t crc_next;

  always_comb begin
    crc_cur  = ctrl.restart ? CRC_INIT : crc;
    crc_next = {8'h00, crc_cur[15:8]} ^ crc_entry(crc_cur[7:0] ^ rx_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else if (ctrl.take) begin
      crc <= crc_next;
    end else if (ctrl.restart) begin
      crc <= CRC_INIT;
    end
  end

  assign crc_value = crc;

endmodule

`default_nettype wire

[rtl/core/mdec_frame.sv]
// Byte position tracking, frame byte store, CRC check and held values.
// Depends on mdec_pkg; drives the control of mdec_crc.
`timescale 1ns / 1ps
`default_nettype none

module mdec_frame
  import mdec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        kind,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_start,
  input  wire crc_t        crc_value,
  output crc_ctrl_t        crc_ctrl,
  output logic             result,
  output logic [15:0]      voltage_raw,
  output logic [31:0]      current_raw,
  output logic [31:0]      power_raw,
  output logic [31:0]      energy_raw,
  output logic [15:0]      frequency_raw,
  output logic [15:0]      power_factor_raw,
  output logic [15:0]      alarm_word,
  output logic [7:0]       device_address,
  output logic             crc_good
);

  pos_t       byte_position;
  pos_t       pos_eff;
  pos_t       pos_next;
  pos_t       len;
  logic       in_frame;
  logic       is_last;
  logic       good;
  logic [7:0] crc_low;
  logic [7:0] frame_bytes [FRAME_BYTES];

  always_comb begin
    len      = kind ? ADDR_LEN : MEAS_LEN;
    pos_eff  = frame_start ? '0 : byte_position;
    in_frame = pos_eff < len;
    pos_next = (pos_eff == POS_MAX) ? POS_MAX : pos_eff + 5'd1;
    is_last  = in_frame && (pos_eff == len - 5'd1);
    crc_low  = kind ? frame_bytes[ADDR_LEN - 5'd2] : frame_bytes[MEAS_LEN - 5'd2];
    good     = ({rx_byte, crc_low} == crc_value);
    result   = step && is_last;
    crc_ctrl.restart = step && frame_start;
    crc_ctrl.take    = step && in_frame && (pos_eff < len - 5'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (step) begin
      byte_position <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_frame) begin
      frame_bytes[pos_eff] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_raw      <= '0;
      current_raw      <= '0;
      power_raw        <= '0;
      energy_raw       <= '0;
      frequency_raw    <= '0;
      power_factor_raw <= '0;
      alarm_word       <= '0;
      device_address   <= '0;
      crc_good         <= 1'b0;
    end else if (result) begin
      crc_good <= good;
      if (good) begin
        if (kind) begin
          device_address <= frame_bytes[4];
        end else begin
          voltage_raw      <= {frame_bytes[3], frame_bytes[4]};
          current_raw      <= {frame_bytes[7], frame_bytes[8],
                               frame_bytes[5], frame_bytes[6]};
          power_raw        <= {frame_bytes[11], frame_bytes[12],
                               frame_bytes[9], frame_bytes[10]};
          energy_raw       <= {frame_bytes[15], frame_bytes[16],
                               frame_bytes[13], frame_bytes[14]};
          frequency_raw    <= {frame_bytes[17], frame_bytes[18]};
          power_factor_raw <= {frame_bytes[19], frame_bytes[20]};
          alarm_word       <= {frame_bytes[21], frame_bytes[22]};
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/mdec_checker.sv]
// Port-level checker for the meter reply frame decoder, bound to the top.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mdec_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] voltage_raw,
  input wire logic [31:0] current_raw,
  input wire logic [31:0] power_raw,
  input wire logic [31:0] energy_raw,
  input wire logic [15:0] frequency_raw,
  input wire logic [15:0] power_factor_raw,
  input wire logic [15:0] alarm_word,
  input wire logic [7:0]  device_address,
  input wire logic        crc_good
);

  logic [159:0] meas_vals;
  logic [168:0] out_vals;

  assign meas_vals = {voltage_raw, current_raw, power_raw, energy_raw,
                      frequency_raw, power_factor_raw, alarm_word};
  assign out_vals  = {meas_vals, device_address, crc_good};

  // no result survives reset
  `ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid)

  // a stalled result holds its payload
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_vals))

  // measured values move only with a fresh good-CRC result
  `ASSERT_CLK(a_meas_commit, $past(!rst) && !$stable(meas_vals) |-> out_valid && crc_good)

  // address moves only with a fresh good-CRC result
  `ASSERT_CLK(a_addr_commit, $past(!rst) && !$stable(device_address) |-> out_valid && crc_good)

  // with the output side empty the input side never stalls
  `ASSERT_CLK(a_no_false_stall, !out_valid |-> in_ready)

endmodule

bind meter_reply_frame_decoder mdec_checker u_mdec_checker (.*);

`default_nettype wire
